// File: design/rate_monotonic_tick_scheduler_unit_assert.svh
// ----------------------------------------------------------------------------
// Rate-monotonic tick scheduler assertion macros
// Property wrappers shared by the scheduler RTL; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_UNIT_ASSERT_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define RMTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rmts assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define RMTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rmts assertion failed");

`else

`define RMTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RMTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: design/rmts_pkg.sv
// ----------------------------------------------------------------------------
// rmts_pkg
// Types and constants shared by the rate-monotonic tick scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmts_pkg;

    // Number of task slots in the register map and result masks
    localparam int SLOTS      = 4;
    localparam int TASK_IDX_W = 2;
    localparam int FIELD_W    = 16;
    localparam int MASK_W     = SLOTS;

    // Configuration port
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [REG_IDX_W-1:0] REG_TASK0   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HORIZON = 3'd4;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;

    // One task timing register: period high, burst low
    typedef struct packed {
        logic [FIELD_W-1:0] period;
        logic [FIELD_W-1:0] burst;
    } timing_t;

    // Arbiter decision
    typedef struct packed {
        logic                  found;
        logic [TASK_IDX_W-1:0] best;
    } pick_t;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic [2:0]            pad;
        logic                  done_res;
        logic [MASK_W-1:0]     killed_mask;
        logic [MASK_W-1:0]     lost_mask;
        logic                  finished;
        logic                  idle;
        logic [TASK_IDX_W-1:0] running_task;
        logic [FIELD_W-1:0]    now;
    } result_t;

endpackage

// File: design/rmts_cfg.sv
// ----------------------------------------------------------------------------
// rmts_cfg
// Configuration register file: per-task timing words and the horizon.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmts_cfg import rmts_pkg::*; #(
    parameter int TASKS = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [REG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output timing_t               timing [TASKS],
    output logic [FIELD_W-1:0]    horizon
);

    timing_t            timing_reg [TASKS];
    logic [FIELD_W-1:0] horizon_reg;

    // Register writes; indexes past the map are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TASKS; i++) begin
                timing_reg[i] <= '0;
            end
            horizon_reg <= '0;
        end else if (wr_en) begin
            for (int i = 0; i < TASKS; i++) begin
                if (wr_index == REG_TASK0 + REG_IDX_W'(i)) begin
                    timing_reg[i] <= wr_data;
                end
            end
            if (wr_index == REG_HORIZON) begin
                horizon_reg <= wr_data[FIELD_W-1:0];
            end
        end
    end

    assign timing  = timing_reg;
    assign horizon = horizon_reg;

endmodule

// File: design/rmts_pick.sv
// ----------------------------------------------------------------------------
// rmts_pick
// Rate-monotonic arbiter: shortest period among pending tasks, lower index
// wins a tie.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmts_pick import rmts_pkg::*; #(
    parameter int TASKS = 4
) (
    input  timing_t          timing [TASKS],
    input  logic [TASKS-1:0] cand,
    output pick_t            pick
);

    logic [FIELD_W-1:0]    best_period;
    logic [TASK_IDX_W-1:0] best_idx;
    logic                  found;

    // Linear scan, strict compare keeps the lower index on a tie
    always_comb begin
        found       = 1'b0;
        best_idx    = '0;
        best_period = '0;
        for (int i = 0; i < TASKS; i++) begin
            if (cand[i] && (!found || timing[i].period < best_period)) begin
                found       = 1'b1;
                best_idx    = TASK_IDX_W'(i);
                best_period = timing[i].period;
            end
        end
        pick.found = found;
        pick.best  = best_idx;
    end

endmodule

// File: design/rate_monotonic_tick_scheduler_unit.sv
// Rate-monotonic tick scheduler. Each input item is one time tick (s_tdata[0]
// set restarts at time zero) and yields exactly one result item. An item is
// taken into an input register and its result lands in the output register at
// the next clock edge unless the output is stalled, from where it is taken
// downstream; the unit takes a new item every cycle while the output is not
// stalled, the whole tick (release, shortest-period pick, countdown, kill
// check) being one pass of logic between those two registers. Configuration
// writes are taken in any cycle (cfg_ready is always high) and must only occur
// while no tick is in flight.
// ----------------------------------------------------------------------------
// rate_monotonic_tick_scheduler_unit
// Top level: stream handshake, scheduler state and per-tick update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rate_monotonic_tick_scheduler_unit_assert.svh"

module rate_monotonic_tick_scheduler_unit import rmts_pkg::*; #(
    parameter int TASKS     = 4,
    parameter int TIME_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Tick input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [0] restart, [7:1] zero
    // Result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // [15:0] now, [17:16] running_task,
                                             // [18] idle, [19] finished,
                                             // [23:20] lost_mask,
                                             // [27:24] killed_mask,
                                             // [28] done_res, [31:29] zero
);

    // Compare width covers both the time counter and the 16-bit horizon
    localparam int CW = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;
    localparam logic [CW-1:0] TIME_MAX = CW'((64'd1 << TIME_BITS) - 64'd1);

    timing_t            timing [TASKS];
    logic [FIELD_W-1:0] horizon;

    // Scheduler state
    logic [TIME_BITS-1:0] time_reg;
    logic [FIELD_W-1:0]   rem_reg   [TASKS];
    logic [FIELD_W-1:0]   phase_reg [TASKS];

    // Pipeline registers
    logic    in_valid_reg;
    logic    restart_reg;
    logic    m_valid_reg;
    result_t m_data_reg;

    logic advance;
    logic fire;

    // Per-tick working values
    logic [CW-1:0]        now_ext;
    logic [CW-1:0]        hz_ext;
    logic [CW-1:0]        limit;
    logic                 at_limit;
    logic [TIME_BITS-1:0] time_next;
    logic                 end_now;
    logic [TASKS-1:0]     en;
    logic [TASKS-1:0]     cand;
    logic [FIELD_W-1:0]   rem_rel    [TASKS];
    logic [FIELD_W-1:0]   rem_next   [TASKS];
    logic [FIELD_W-1:0]   phase_next [TASKS];
    logic [MASK_W-1:0]    lost_v;
    logic [MASK_W-1:0]    killed_v;
    logic                 fin;
    pick_t                pk;
    result_t              res;

    // Configuration registers
    assign cfg_ready = 1'b1;

    rmts_cfg #(.TASKS(TASKS)) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .timing   (timing),
        .horizon  (horizon)
    );

    // Handshake: the input register refills whenever the result slot frees
    assign advance  = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Horizon check, clipped to the counter range
    always_comb begin
        now_ext   = CW'(time_reg);
        hz_ext    = CW'(horizon);
        limit     = (hz_ext > TIME_MAX) ? TIME_MAX : hz_ext;
        at_limit  = now_ext >= limit;
        time_next = time_reg + 1'b1;
        end_now   = CW'(time_next) >= limit;
    end

    // Releases: reload burst, restart countdown, flag a replaced job
    always_comb begin
        lost_v = '0;
        for (int i = 0; i < TASKS; i++) begin
            en[i]         = timing[i].period != '0;
            rem_rel[i]    = rem_reg[i];
            phase_next[i] = phase_reg[i];
            if (en[i]) begin
                if (phase_reg[i] == '0) begin
                    lost_v[i]     = rem_reg[i] != '0;
                    rem_rel[i]    = timing[i].burst;
                    phase_next[i] = timing[i].period - 1'b1;
                end else begin
                    phase_next[i] = phase_reg[i] - 1'b1;
                end
            end
            cand[i] = en[i] && (rem_rel[i] != '0);
        end
    end

    rmts_pick #(.TASKS(TASKS)) u_pick (
        .timing (timing),
        .cand   (cand),
        .pick   (pk)
    );

    // Run the chosen job one unit, then kill leftovers at the horizon
    always_comb begin
        fin      = 1'b0;
        killed_v = '0;
        for (int i = 0; i < TASKS; i++) begin
            rem_next[i] = rem_rel[i];
            if (pk.found && pk.best == TASK_IDX_W'(i)) begin
                rem_next[i] = rem_rel[i] - 1'b1;
                fin         = rem_rel[i] == FIELD_W'(1);
            end
            if (end_now) begin
                killed_v[i] = rem_next[i] != '0;
                rem_next[i] = '0;
            end
        end
    end

    // Result item
    always_comb begin
        res      = '0;
        res.idle = 1'b1;
        if (!restart_reg) begin
            res.now = FIELD_W'(now_ext);
            if (at_limit) begin
                res.done_res = 1'b1;
            end else begin
                res.running_task = pk.found ? pk.best : '0;
                res.idle         = !pk.found;
                res.finished     = fin;
                res.lost_mask    = lost_v;
                res.killed_mask  = killed_v;
            end
        end
    end

    // Pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            restart_reg <= s_tdata[0];
        end
        if (fire) begin
            m_data_reg <= res;
        end
    end

    // Scheduler state update, once per tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
            for (int i = 0; i < TASKS; i++) begin
                rem_reg[i]   <= '0;
                phase_reg[i] <= '0;
            end
        end else if (fire) begin
            if (restart_reg) begin
                time_reg <= '0;
                for (int i = 0; i < TASKS; i++) begin
                    rem_reg[i]   <= '0;
                    phase_reg[i] <= '0;
                end
            end else if (!at_limit) begin
                time_reg <= time_next;
                for (int i = 0; i < TASKS; i++) begin
                    rem_reg[i]   <= rem_next[i];
                    phase_reg[i] <= phase_next[i];
                end
            end
        end
    end

    // Checks
    `RMTS_ASSERT_NEXT(a_time_step, aclk, aresetn, fire && !restart_reg && !at_limit, time_reg == $past(time_reg) + 1'b1)
    `RMTS_ASSERT_NEXT(a_hold_item, aclk, aresetn, in_valid_reg && !advance, in_valid_reg)
    `RMTS_ASSERT_IMPL(a_done_quiet, aclk, aresetn, m_valid_reg && m_data_reg.done_res, m_data_reg.idle && m_data_reg.lost_mask == '0 && m_data_reg.killed_mask == '0)

endmodule
